// ===== rtl/bts_pkg.sv =====
// Shared types and constants of the byte-time token bucket shaper.
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

   // Operation codes of an input item.
   localparam logic OP_TIME   = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_BYTES       = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CREDITS_PER_PERIOD = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_SIZE        = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_OVERHEAD     = 8'd3;

   // Field and state widths.
   localparam int TIME_W   = 64;
   localparam int CREDIT_W = 32;
   localparam int ELAPSED_W = 32;
   localparam int LENGTH_W = 16;
   localparam int OVH_W    = 8;
   localparam int COST_W   = 17;

   // Reset values of the configuration registers.
   localparam logic [31:0] RST_PERIOD_BYTES       = 32'd1;
   localparam logic [31:0] RST_CREDITS_PER_PERIOD = 32'd1;
   localparam logic [31:0] RST_BUCKET_SIZE        = 32'd4096;
   localparam logic [7:0]  RST_FRAME_OVERHEAD     = 8'd24;
   localparam logic [31:0] RST_CREDITS            = RST_BUCKET_SIZE / 2;

   // Divider: 64-bit dividend, 32-bit divisor, two quotient bits per cycle.
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_CYCLES         = TIME_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   dividend;
      logic [31:0]         divisor;
   } bts_div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [TIME_W-1:0]   quotient;
      logic [31:0]         remainder;
   } bts_div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/bts_ifs.sv =====
// Valid/ready channel interfaces for requests and responses of the shaper.
`timescale 1ns / 1ps
`default_nettype none

interface bts_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] elapsed_bytes;
   logic [15:0] packet_length;

   modport source (output valid, output operation, output elapsed_bytes,
                   output packet_length, input ready);
   modport sink   (input valid, input operation, input elapsed_bytes,
                   input packet_length, output ready);
endinterface

interface bts_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [31:0] credits_left;

   modport source (output valid, output granted, output credits_left, input ready);
   modport sink   (input valid, input granted, input credits_left, output ready);
endinterface

`default_nettype wire

// ===== rtl/bts_div.sv =====
// Iterative 64-by-32 unsigned divider, two quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bts_div
   import bts_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bts_div_req_type div_req,
   output wire bts_div_rsp_type div_rsp
);

   logic [TIME_W-1:0]    quot_ff, quot_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [TIME_W-1:0]    quot_step;
   logic [31:0]          rem_step;

   // Restoring division: shift a dividend bit into the remainder, subtract
   // when the divisor fits and record a one in the quotient.
   always_comb begin
      logic [32:0] trial;
      quot_step = quot_ff;
      rem_step  = rem_ff;
      for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
         trial     = {rem_step, quot_step[TIME_W-1]};
         quot_step = {quot_step[TIME_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial        = trial - {1'b0, divisor_ff};
            quot_step[0] = 1'b1;
         end
         rem_step = trial[31:0];
      end
   end

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quot_in = quot_step;
         rem_in  = rem_step;
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/byte_time_token_bucket_shaper_top.sv =====
// Top level of the byte-time token bucket shaper: sequencer, state and ports.
// A packet item passes from idle through the division, sum, charge and output states
// before the next item can be accepted. A time item goes straight to the output
// state and a packet item with a zero refill period straight to the charge state; an
// unclaimed result still in the output register stretches any item by its wait.
// Synchronous reset restores register defaults, zero times and half-bucket credits.
`timescale 1ns / 1ps
`default_nettype none

module byte_time_token_bucket_shaper_top
   import bts_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   bts_req_if.sink                     req_ch,
   bts_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
   localparam logic [2:0] ST_DIV  = 3'd1;  // divider computes whole periods
   localparam logic [2:0] ST_SUM  = 3'd2;  // add refill credits and clamp
   localparam logic [2:0] ST_CHG  = 3'd3;  // grant check and charge
   localparam logic [2:0] ST_OUT  = 3'd4;  // hand result to output register

   logic [2:0]          state_ff, state_in;

   // Configuration registers.
   logic [31:0]         period_bytes_ff, period_bytes_in;
   logic [31:0]         credits_per_period_ff, credits_per_period_in;
   logic [31:0]         bucket_size_ff, bucket_size_in;
   logic [OVH_W-1:0]    frame_overhead_ff, frame_overhead_in;

   // Shaper state.
   logic [TIME_W-1:0]   port_time_ff, port_time_in;
   logic [TIME_W-1:0]   wall_time_ff, wall_time_in;
   logic [TIME_W-1:0]   bucket_time_ff, bucket_time_in;
   logic [CREDIT_W-1:0] credits_ff, credits_in;

   // Per-item working registers.
   logic [COST_W-1:0]   cost_ff, cost_in;
   logic [TIME_W-1:0]   prod_ff, prod_in;
   logic                sat_ff, sat_in;
   logic                granted_ff, granted_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [CREDIT_W-1:0] rsp_credits_ff, rsp_credits_in;

   bts_div_req_type     div_req;
   bts_div_rsp_type     div_rsp;

   logic                req_xfer;
   logic [TIME_W-1:0]   wall_sum;
   logic [TIME_W-1:0]   refill_total;

   // The divider turns elapsed port time into whole refill periods.
   bts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A new item is taken only when the sequencer is idle. The output register
   // lets an item be accepted while the previous result is still unclaimed.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && (state_ff == ST_IDLE);

   assign wall_sum     = wall_time_ff + {32'b0, req_ch.elapsed_bytes};
   assign refill_total = {32'b0, credits_ff} + prod_ff;

   always_comb begin
      state_in              = state_ff;
      period_bytes_in       = period_bytes_ff;
      credits_per_period_in = credits_per_period_ff;
      bucket_size_in        = bucket_size_ff;
      frame_overhead_in     = frame_overhead_ff;
      port_time_in          = port_time_ff;
      wall_time_in          = wall_time_ff;
      bucket_time_in        = bucket_time_ff;
      credits_in            = credits_ff;
      cost_in               = cost_ff;
      prod_in               = prod_ff;
      sat_in                = sat_ff;
      granted_in            = granted_ff;
      rsp_valid_in          = rsp_valid_ff;
      rsp_granted_in        = rsp_granted_ff;
      rsp_credits_in        = rsp_credits_ff;

      // The divider always works on the elapsed port time since the last
      // refill; the start pulse is raised only for a packet item.
      div_req.start    = 1'b0;
      div_req.dividend = port_time_ff - bucket_time_ff;
      div_req.divisor  = period_bytes_ff;

      // Register writes; indexes beyond the list are ignored.
      if (csr_we) begin
         case (csr_index)
            CSR_PERIOD_BYTES:       period_bytes_in       = csr_wdata;
            CSR_CREDITS_PER_PERIOD: credits_per_period_in = csr_wdata;
            CSR_BUCKET_SIZE:        bucket_size_in        = csr_wdata;
            CSR_FRAME_OVERHEAD:     frame_overhead_in     = csr_wdata[OVH_W-1:0];
            default: ;
         endcase
      end

      // A transfer on the result channel frees the output register.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               granted_in = 1'b0;
               if (req_ch.operation == OP_TIME) begin
                  // Advance wall time; port time never lags behind it.
                  wall_time_in = wall_sum;
                  if (port_time_ff < wall_sum) begin
                     port_time_in = wall_sum;
                  end
                  state_in = ST_OUT;
               end else begin
                  cost_in = COST_W'(req_ch.packet_length) + COST_W'(frame_overhead_ff);
                  if (period_bytes_ff == '0) begin
                     // A zero period disables refill altogether.
                     state_in = ST_CHG;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               // Moving bucket time by the whole periods lands it exactly
               // the remainder short of port time.
               bucket_time_in = port_time_ff - {32'b0, div_rsp.remainder};
               prod_in  = {32'b0, div_rsp.quotient[31:0]} *
                          {32'b0, credits_per_period_ff};
               sat_in   = (div_rsp.quotient[TIME_W-1:32] != '0) &&
                          (credits_per_period_ff != '0);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // 2^32 or more periods with a nonzero rate always fill the
            // bucket; otherwise the sum cannot wrap in 64 bits.
            if (sat_ff || (refill_total > {32'b0, bucket_size_ff})) begin
               credits_in = bucket_size_ff;
            end else begin
               credits_in = refill_total[CREDIT_W-1:0];
            end
            state_in = ST_CHG;
         end
         ST_CHG: begin
            if ({15'b0, cost_ff} <= credits_ff) begin
               credits_in   = credits_ff - {15'b0, cost_ff};
               port_time_in = port_time_ff + {47'b0, cost_ff};
               granted_in   = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_credits_in = credits_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         period_bytes_ff       <= RST_PERIOD_BYTES;
         credits_per_period_ff <= RST_CREDITS_PER_PERIOD;
         bucket_size_ff        <= RST_BUCKET_SIZE;
         frame_overhead_ff     <= RST_FRAME_OVERHEAD;
         port_time_ff          <= '0;
         wall_time_ff          <= '0;
         bucket_time_ff        <= '0;
         credits_ff            <= RST_CREDITS;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff              <= state_in;
         period_bytes_ff       <= period_bytes_in;
         credits_per_period_ff <= credits_per_period_in;
         bucket_size_ff        <= bucket_size_in;
         frame_overhead_ff     <= frame_overhead_in;
         port_time_ff          <= port_time_in;
         wall_time_ff          <= wall_time_in;
         bucket_time_ff        <= bucket_time_in;
         credits_ff            <= credits_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
      cost_ff        <= cost_in;
      prod_ff        <= prod_in;
      sat_ff         <= sat_in;
      granted_ff     <= granted_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_credits_ff <= rsp_credits_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted      = rsp_granted_ff;
   assign rsp_ch.credits_left = rsp_credits_ff;

`ifndef SYNTHESIS
   // The divider reports completion only to a sequencer that waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the division state");

   // After a refill the bucket time trails port time by less than one period.
   a_bucket_time_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_rsp.done) |=>
         ((port_time_ff - bucket_time_ff) < {32'b0, period_bytes_ff}))
      else $error("bucket time not within one period of port time");

   // A refill never leaves more credits than the bucket holds.
   a_refill_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |=> (credits_ff <= bucket_size_ff))
      else $error("credits exceed bucket size after refill");

   // A time item leaves port time at or above wall time.
   a_port_not_behind: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.operation == OP_TIME) |=> (port_time_ff >= wall_time_ff))
      else $error("port time lags wall time after a time item");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the byte-time token bucket shaper.
`timescale 1ns / 1ps

module testbench
   import bts_pkg::*;
();

   // Clock and reset timing.
   localparam int HALF_PERIOD_NS = 5;
   localparam int RESET_CYCLES   = 8;

   // Random traffic: several shaping profiles, each programmed while the block is idle.
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 205;

   // The sequencer returns to its idle state as it hands a result to the output register,
   // so it is already idle when the last result has been taken.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 60;

   // Backpressure events, placed in the middle of a phase.
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_AT_ITEM  = 320;
   localparam int PAUSE_AT_ITEM = 700;

   // About 1250 items, the sender gaps between bursts, receiver stalls, the long hold-off
   // and the quiet spells around register writes stay well within this limit.
   localparam int LIMIT_CYCLES = 1_000_000;

   typedef struct packed {
      logic                granted;
      logic [CREDIT_W-1:0] credits_left;
   } shaper_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One row of the directed table: either a transfer on the request channel or a
   // register write. The value column is the elapsed byte count of a time item or the
   // write data of a register write. Rows marked as typed carry the result by hand.
   typedef struct {
      row_kind_type           kind;
      logic                   operation;
      logic [31:0]            value;
      logic [LENGTH_W-1:0]    length;
      logic [CSR_INDEX_W-1:0] index;
      bit                     typed;
      shaper_result_type      expected;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 31;

   // The first rows start from the reset state: period 1, one credit per period,
   // bucket of 4096 holding 2048 credits, frame overhead of 24 bytes.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // A time item never refills and reports the untouched half-full bucket.
      '{ROW_ITEM, OP_TIME,   32'd0,         16'd0,    8'd0, 1'b1, '{1'b0, 32'd2048}},
      // A zero-length packet is charged the frame overhead alone.
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd0,    8'd0, 1'b1, '{1'b1, 32'd2024}},
      // The longest packet: the refill returns the 24 credits, the packet still does not fit.
      '{ROW_ITEM, OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 8'd0, 1'b1, '{1'b0, 32'd2048}},
      // Three maximal time steps push the lag beyond 2^32 whole periods.
      '{ROW_ITEM, OP_TIME,   32'hFFFF_FFFF, 16'hFFFF, 8'd0, 1'b1, '{1'b0, 32'd2048}},
      '{ROW_ITEM, OP_TIME,   32'hFFFF_FFFF, 16'd0,    8'd0, 1'b1, '{1'b0, 32'd2048}},
      '{ROW_ITEM, OP_TIME,   32'hFFFF_FFFF, 16'd0,    8'd0, 1'b1, '{1'b0, 32'd2048}},
      // That refill saturates at the bucket size before the packet is charged.
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd2000, 8'd0, 1'b1, '{1'b1, 32'd2072}},
      '{ROW_CSR,  OP_TIME,   32'd0,         16'd0,    CSR_FRAME_OVERHEAD,     1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd0,    8'd0, 1'b0, '0},
      // With a zero period nothing is refilled and the bucket is drained to empty.
      '{ROW_CSR,  OP_TIME,   32'd0,         16'd0,    CSR_PERIOD_BYTES,       1'b0, '0},
      '{ROW_ITEM, OP_TIME,   32'd1000,      16'd0,    8'd0, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd4096, 8'd0, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd0,    8'd0, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd1,    8'd0, 1'b0, '0},
      // Largest period and largest credit step.
      '{ROW_CSR,  OP_TIME,   32'hFFFF_FFFF, 16'd0,    CSR_PERIOD_BYTES,       1'b0, '0},
      '{ROW_CSR,  OP_TIME,   32'hFFFF_FFFF, 16'd0,    CSR_CREDITS_PER_PERIOD, 1'b0, '0},
      '{ROW_ITEM, OP_TIME,   32'hFFFF_FFFF, 16'd0,    8'd0, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd10,   8'd0, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'hFFFF, 8'd0, 1'b0, '0},
      // No credits per period: bucket time still moves by the whole periods.
      '{ROW_CSR,  OP_TIME,   32'd0,         16'd0,    CSR_CREDITS_PER_PERIOD, 1'b0, '0},
      '{ROW_CSR,  OP_TIME,   32'd1,         16'd0,    CSR_PERIOD_BYTES,       1'b0, '0},
      '{ROW_ITEM, OP_TIME,   32'd5000,      16'd0,    8'd0, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'hFFFF, 8'd0, 1'b0, '0},
      // Shrinking the bucket clamps the credits at the next packet's refill.
      '{ROW_CSR,  OP_TIME,   32'd1,         16'd0,    CSR_BUCKET_SIZE,        1'b0, '0},
      '{ROW_CSR,  OP_TIME,   32'd1,         16'd0,    CSR_CREDITS_PER_PERIOD, 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd0,    8'd0, 1'b0, '0},
      // Only the low byte of the write data reaches the overhead register.
      '{ROW_CSR,  OP_TIME,   32'hFFFF_FFFF, 16'd0,    CSR_FRAME_OVERHEAD,     1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'd0,    8'd0, 1'b0, '0},
      '{ROW_CSR,  OP_TIME,   32'hFFFF_FFFF, 16'd0,    CSR_BUCKET_SIZE,        1'b0, '0},
      // A write to an index past the last register must change nothing.
      '{ROW_CSR,  OP_TIME,   32'd0,         16'd0,    8'd200,                 1'b0, '0},
      '{ROW_ITEM, OP_PACKET, 32'd0,         16'hFFFF, 8'd0, 1'b0, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bts_req_if req_bus ();
   bts_rsp_if rsp_bus ();

   byte_time_token_bucket_shaper_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the shaping profile and of the bucket state.
   logic [31:0]         cfg_period_bytes;
   logic [31:0]         cfg_credits_per_period;
   logic [31:0]         cfg_bucket_size;
   logic [OVH_W-1:0]    cfg_frame_overhead;
   logic [TIME_W-1:0]   port_time;
   logic [TIME_W-1:0]   wall_time;
   logic [TIME_W-1:0]   bucket_time;
   logic [CREDIT_W-1:0] credit_balance;

   // Decisions still owed by the block, oldest first.
   shaper_result_type pending_results [$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count    = 0;
   bit                hold_off_request = 1'b0;

   always begin
      #HALF_PERIOD_NS clock = 1'b1;
      #HALF_PERIOD_NS clock = 1'b0;
   end

   // Works out the decision for one accepted transfer and advances the shadow state.
   // With a nonzero period, a packet first collects the credits of every whole period of
   // port time since the last refill, clamped to the bucket size, and is then granted if
   // its length plus the frame overhead fits in the credits.
   function automatic shaper_result_type shape_item(logic operation,
                                                    logic [ELAPSED_W-1:0] elapsed,
                                                    logic [LENGTH_W-1:0] length);
      shaper_result_type result;
      logic [TIME_W-1:0] periods;
      logic [TIME_W-1:0] refill_total;
      logic [31:0]       cost;
      result.granted = 1'b0;
      if (operation == OP_TIME) begin
         wall_time = wall_time + TIME_W'(elapsed);
         if (port_time < wall_time) port_time = wall_time;
      end else begin
         if (cfg_period_bytes != '0) begin
            periods     = (port_time - bucket_time) / TIME_W'(cfg_period_bytes);
            bucket_time = bucket_time + periods * TIME_W'(cfg_period_bytes);
            if (cfg_credits_per_period == '0 || periods == '0)
               refill_total = TIME_W'(credit_balance);
            else if (periods > 64'h0000_0000_FFFF_FFFF)
               refill_total = '1;
            else
               refill_total = TIME_W'(credit_balance)
                              + periods * TIME_W'(cfg_credits_per_period);
            if (refill_total > TIME_W'(cfg_bucket_size))
               refill_total = TIME_W'(cfg_bucket_size);
            credit_balance = refill_total[CREDIT_W-1:0];
         end
         cost = 32'(length) + 32'(cfg_frame_overhead);
         if (cost <= credit_balance) begin
            credit_balance = credit_balance - cost;
            port_time      = port_time + TIME_W'(cost);
            result.granted = 1'b1;
         end
      end
      result.credits_left = credit_balance;
      return result;
   endfunction

   // Offers one item and holds it until the transfer. Valid stays high afterwards so
   // that a following item can go out back to back; the caller lowers it for a gap.
   task automatic send_item(logic operation, logic [ELAPSED_W-1:0] elapsed,
                            logic [LENGTH_W-1:0] length, bit typed,
                            shaper_result_type typed_result);
      shaper_result_type predicted;
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= operation;
      req_bus.elapsed_bytes <= elapsed;
      req_bus.packet_length <= length;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      // The shadow state advances even where the row carries its result by hand.
      predicted = shape_item(operation, elapsed, length);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Stops offering items and waits until every decision has come back, then lets
   // the given number of cycles pass.
   task automatic wait_results_drained(int unsigned settle);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_PERIOD_BYTES:       cfg_period_bytes       = data;
         CSR_CREDITS_PER_PERIOD: cfg_credits_per_period = data;
         CSR_BUCKET_SIZE:        cfg_bucket_size        = data;
         CSR_FRAME_OVERHEAD:     cfg_frame_overhead     = data[OVH_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Picks a shaping profile that mostly lets a fair share of packets through, with
   // the register extremes mixed in, and writes every register plus a stray index.
   task automatic program_shaping_profile();
      logic [31:0]      period;
      logic [31:0]      credit_step;
      logic [31:0]      size;
      logic [OVH_W-1:0] overhead;
      case ($urandom_range(0, 5))
         0:       period = '0;
         1:       period = '1;
         2:       period = 32'd1;
         default: period = $urandom_range(1, 2000);
      endcase
      case ($urandom_range(0, 5))
         0:       credit_step = '0;
         1:       credit_step = '1;
         2:       credit_step = 32'd1;
         default: credit_step = $urandom_range(1, 2000);
      endcase
      case ($urandom_range(0, 5))
         0:       size = 32'd1;
         1:       size = '1;
         default: size = $urandom_range(64, 200000);
      endcase
      case ($urandom_range(0, 4))
         0:       overhead = '0;
         1:       overhead = '1;
         default: overhead = $urandom_range(0, 64);
      endcase
      write_register(CSR_PERIOD_BYTES, period);
      write_register(CSR_CREDITS_PER_PERIOD, credit_step);
      write_register(CSR_BUCKET_SIZE, size);
      write_register(CSR_FRAME_OVERHEAD, {24'($urandom()), overhead});
      write_register(CSR_INDEX_W'($urandom_range(4, 255)), $urandom());
   endtask

   // A random item: mostly packets of everyday sizes and modest time steps, with
   // field extremes and fully random values mixed in. The field that the operation
   // does not use is randomized as well.
   task automatic send_random_item();
      logic                 operation;
      logic [ELAPSED_W-1:0] elapsed;
      logic [LENGTH_W-1:0]  length;
      operation = ($urandom_range(0, 9) < 6) ? OP_PACKET : OP_TIME;
      case ($urandom_range(0, 9))
         0:       elapsed = '0;
         1:       elapsed = '1;
         2, 3:    elapsed = $urandom();
         4, 5:    elapsed = $urandom_range(0, 100000);
         default: elapsed = $urandom_range(0, 2000);
      endcase
      case ($urandom_range(0, 9))
         0:       length = '1;
         1:       length = '0;
         2:       length = LENGTH_W'($urandom());
         default: length = $urandom_range(0, 1500);
      endcase
      send_item(operation, elapsed, length, 1'b0, '0);
   endtask

   // Stimulus: reset, the directed table, then the random phases.
   initial begin : stimulus
      int unsigned item_total;
      int unsigned burst_left;
      int unsigned gap;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_TIME;
      req_bus.elapsed_bytes <= '0;
      req_bus.packet_length <= '0;
      cfg_period_bytes       = RST_PERIOD_BYTES;
      cfg_credits_per_period = RST_CREDITS_PER_PERIOD;
      cfg_bucket_size        = RST_BUCKET_SIZE;
      cfg_frame_overhead     = RST_FRAME_OVERHEAD;
      port_time              = '0;
      wall_time              = '0;
      bucket_time            = '0;
      credit_balance         = RST_CREDITS;
      item_total             = 0;
      burst_left             = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Registers only change once the block has gone quiet.
      foreach (directed_rows[row]) begin
         if (directed_rows[row].kind == ROW_CSR) begin
            wait_results_drained(SETTLE_CYCLES);
            write_register(directed_rows[row].index, directed_rows[row].value);
         end else begin
            send_item(directed_rows[row].operation, directed_rows[row].value,
                      directed_rows[row].length, directed_rows[row].typed,
                      directed_rows[row].expected);
         end
      end

      // Random part. The sender works in bursts of random length separated by gaps
      // of random length, and some bursts run back to back. Each phase boundary is
      // also a point where the sender waits for every outstanding decision.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_results_drained(SETTLE_CYCLES);
         program_shaping_profile();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
               if (gap != 0) begin
                  req_bus.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            // Ask the receiver to stop for a long while; the sender keeps offering,
            // so the block fills up and stops accepting.
            if (item_total == HOLD_AT_ITEM) hold_off_request = 1'b1;
            // Mid-phase, the sender stops until every decision has come back.
            if (item_total == PAUSE_AT_ITEM) wait_results_drained(1);
            send_random_item();
            item_total++;
         end
      end

      wait_results_drained(DRAIN_CYCLES);
      if (pending_results.size() != 0) begin
         $error("%0d decisions never arrived", pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Receiver: changes its stall pattern at random intervals between always
   // ready, coin tosses, a fixed duty pattern and rare stalls. Once during the random
   // part it withholds ready for a long stretch that it counts itself.
   initial begin : receiver
      int unsigned mode;
      int unsigned mode_left;
      int unsigned pattern_step;
      mode          = 0;
      mode_left     = 0;
      pattern_step  = 0;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         pattern_step++;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= (pattern_step % 7) >= 2;
            default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Every transfer on the response channel is compared with the oldest decision
   // still owed.
   always @(posedge clock) begin : result_checker
      shaper_result_type expected;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: granted %0b, credits_left %0d",
                   rsp_bus.granted, rsp_bus.credits_left);
            mismatch_count++;
         end else begin
            expected = pending_results.pop_front();
            if (rsp_bus.granted !== expected.granted) begin
               $error("granted: expected %0b, actual %0b",
                      expected.granted, rsp_bus.granted);
               mismatch_count++;
            end
            if (rsp_bus.credits_left !== expected.credits_left) begin
               $error("credits_left: expected %0d, actual %0d",
                      expected.credits_left, rsp_bus.credits_left);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
